@@ hdl/cpbw_pkg.sv @@
`default_nettype none

package cpbw_pkg;

	localparam int unsigned CH_W = 8;
	localparam int unsigned COORD_W = 12;
	localparam int unsigned PADDR_W = 5;
	localparam int unsigned REG_IDX_W = 3;

	localparam logic [COORD_W-1:0] MAX_WIDTH = 12'd3840;
	localparam logic [COORD_W-1:0] MAX_HEIGHT = 12'd2160;

	localparam logic [REG_IDX_W-1:0] REG_CLIP_ENABLE = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_CLIP_LEFT = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_CLIP_TOP = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_CLIP_RIGHT = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_CLIP_BOTTOM = 3'd4;
	localparam logic [REG_IDX_W-1:0] REG_RENDER_WIDTH = 3'd5;
	localparam logic [REG_IDX_W-1:0] REG_RENDER_HEIGHT = 3'd6;

	localparam logic [1:0] KIND_FILL = 2'd0;
	localparam logic [1:0] KIND_ALPHA_FILL = 2'd1;
	localparam logic [1:0] KIND_BLIT = 2'd2;

	typedef struct packed {
		logic clip_enable;
		logic [COORD_W-1:0] clip_left;
		logic [COORD_W-1:0] clip_top;
		logic [COORD_W-1:0] clip_right;
		logic [COORD_W-1:0] clip_bottom;
		logic [COORD_W-1:0] render_width;
		logic [COORD_W-1:0] render_height;
	} cfg_t;

endpackage

`default_nettype wire

@@ hdl/cpbw_regs.sv @@
`default_nettype none

module cpbw_regs (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic psel,
	input wire logic penable,
	input wire logic pwrite,
	input wire logic [cpbw_pkg::PADDR_W-1:0] paddr,
	input wire logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready,
	output cpbw_pkg::cfg_t cfg
);

	cpbw_pkg::cfg_t cfg_q;
	logic [cpbw_pkg::REG_IDX_W-1:0] idx;
	logic wr;

	assign idx = paddr[cpbw_pkg::PADDR_W-1:2];
	assign wr = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (wr) begin
			unique case (idx)
				cpbw_pkg::REG_CLIP_ENABLE: cfg_q.clip_enable <= pwdata[0];
				cpbw_pkg::REG_CLIP_LEFT: cfg_q.clip_left <= pwdata[11:0];
				cpbw_pkg::REG_CLIP_TOP: cfg_q.clip_top <= pwdata[11:0];
				cpbw_pkg::REG_CLIP_RIGHT: cfg_q.clip_right <= pwdata[11:0];
				cpbw_pkg::REG_CLIP_BOTTOM: cfg_q.clip_bottom <= pwdata[11:0];
				cpbw_pkg::REG_RENDER_WIDTH: cfg_q.render_width <= pwdata[11:0];
				cpbw_pkg::REG_RENDER_HEIGHT: cfg_q.render_height <= pwdata[11:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			cpbw_pkg::REG_CLIP_ENABLE: prdata = {31'd0, cfg_q.clip_enable};
			cpbw_pkg::REG_CLIP_LEFT: prdata = {20'd0, cfg_q.clip_left};
			cpbw_pkg::REG_CLIP_TOP: prdata = {20'd0, cfg_q.clip_top};
			cpbw_pkg::REG_CLIP_RIGHT: prdata = {20'd0, cfg_q.clip_right};
			cpbw_pkg::REG_CLIP_BOTTOM: prdata = {20'd0, cfg_q.clip_bottom};
			cpbw_pkg::REG_RENDER_WIDTH: prdata = {20'd0, cfg_q.render_width};
			cpbw_pkg::REG_RENDER_HEIGHT: prdata = {20'd0, cfg_q.render_height};
			default: prdata = 32'd0;
		endcase
	end

endmodule

`default_nettype wire

@@ hdl/clipped_pixel_blend_writer_core.sv @@
// An accepted input beat passes through the stage 1, 2, 3 and 4 registers to its result beat.
// Throughput: one pixel per cycle; the four register stages advance together,
// and a stalled result beat holds every stage.
// Reset clears all stage valid bits and all configuration registers to zero.
// Configuration writes take effect on the next accepted pixel.
`default_nettype none

module clipped_pixel_blend_writer_core (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic psel,
	input wire logic penable,
	input wire logic pwrite,
	input wire logic [cpbw_pkg::PADDR_W-1:0] paddr,
	input wire logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready,
	input wire logic pix_valid,
	output logic pix_stall,
	input wire logic [1:0] kind,
	input wire logic signed [12:0] pixel_x,
	input wire logic signed [12:0] pixel_y,
	input wire logic [31:0] old_pixel,
	input wire logic [31:0] color,
	input wire logic [7:0] alpha,
	output logic wr_valid,
	input wire logic wr_stall,
	output logic write_enable,
	output logic [31:0] new_pixel
);

	localparam logic [1:0] SEL_OLD = 2'd0;
	localparam logic [1:0] SEL_COLOR = 2'd1;
	localparam logic [1:0] SEL_BLEND = 2'd2;

	cpbw_pkg::cfg_t cfg;

	cpbw_regs u_regs (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.cfg(cfg)
	);

	logic adv;
	logic valid_s1, valid_s2, valid_s3, valid_s4;

	assign adv = !valid_s4 || !wr_stall;
	assign pix_stall = !adv;

	// Stage 1: visibility test.
	logic [11:0] rw, rh, xu, yu;
	logic in_area, in_clip, vis;
	logic vis_s1;
	logic [1:0] kind_s1;
	logic [31:0] old_s1, color_s1;
	logic [7:0] alpha_s1;

	assign xu = pixel_x[11:0];
	assign yu = pixel_y[11:0];
	assign rw = (cfg.render_width > cpbw_pkg::MAX_WIDTH) ? cpbw_pkg::MAX_WIDTH
		: cfg.render_width;
	assign rh = (cfg.render_height > cpbw_pkg::MAX_HEIGHT) ? cpbw_pkg::MAX_HEIGHT
		: cfg.render_height;
	assign in_area = !pixel_x[12] && !pixel_y[12] && (xu < rw) && (yu < rh);
	assign in_clip = !cfg.clip_enable || ((xu >= cfg.clip_left) && (xu < cfg.clip_right)
		&& (yu >= cfg.clip_top) && (yu < cfg.clip_bottom));
	assign vis = in_area && in_clip;

	always_ff @(posedge clk) begin
		if (adv) begin
			vis_s1 <= vis;
			kind_s1 <= kind;
			old_s1 <= old_pixel;
			color_s1 <= color;
			alpha_s1 <= alpha;
		end
	end

	// Stage 2: mode decision and channel products.
	logic we_d2;
	logic [1:0] sel_d2;
	logic [2:0][15:0] prod_d2;
	logic we_s2;
	logic [1:0] sel_s2;
	logic [31:0] old_s2, color_s2;
	logic [2:0][15:0] prod_s2;

	always_comb begin
		logic [15:0] o16, n16, a16, ia16;
		logic [16:0] sum;
		we_d2 = 1'b0;
		sel_d2 = SEL_OLD;
		case (kind_s1)
			cpbw_pkg::KIND_FILL: begin
				we_d2 = vis_s1;
				sel_d2 = vis_s1 ? SEL_COLOR : SEL_OLD;
			end
			cpbw_pkg::KIND_ALPHA_FILL, cpbw_pkg::KIND_BLIT: begin
				we_d2 = vis_s1 && (alpha_s1 != 8'd0);
				sel_d2 = we_d2 ? SEL_BLEND : SEL_OLD;
			end
			default: begin
			end
		endcase
		a16 = {8'd0, alpha_s1};
		ia16 = {8'd0, 8'd255 - alpha_s1};
		for (int c = 0; c < 3; c++) begin
			// A blit blends over black, so its old channel is taken as zero.
			o16 = (kind_s1 == cpbw_pkg::KIND_ALPHA_FILL) ? {8'd0, old_s1[8*c +: 8]} : 16'd0;
			n16 = {8'd0, color_s1[8*c +: 8]};
			sum = 17'(o16 * ia16) + 17'(n16 * a16);
			prod_d2[c] = sum[15:0];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			we_s2 <= we_d2;
			sel_s2 <= sel_d2;
			old_s2 <= old_s1;
			color_s2 <= color_s1;
			prod_s2 <= prod_d2;
		end
	end

	// Stage 3: exact division by 255 for products up to 255 * 255.
	logic [2:0][7:0] quot_d3;
	logic we_s3;
	logic [1:0] sel_s3;
	logic [31:0] old_s3, color_s3;
	logic [2:0][7:0] quot_s3;

	always_comb begin
		logic [16:0] t;
		for (int c = 0; c < 3; c++) begin
			t = {1'b0, prod_s2[c]} + 17'd1 + {9'd0, prod_s2[c][15:8]};
			quot_d3[c] = t[15:8];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			we_s3 <= we_s2;
			sel_s3 <= sel_s2;
			old_s3 <= old_s2;
			color_s3 <= color_s2;
			quot_s3 <= quot_d3;
		end
	end

	// Stage 4: result register.
	logic we_s4;
	logic [31:0] pix_s4;
	logic [31:0] pix_d4;

	always_comb begin
		case (sel_s3)
			SEL_COLOR: pix_d4 = color_s3;
			SEL_BLEND: pix_d4 = {8'hFF, quot_s3[2], quot_s3[1], quot_s3[0]};
			default: pix_d4 = old_s3;
		endcase
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			we_s4 <= we_s3;
			pix_s4 <= pix_d4;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= pix_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
		end
	end

	assign wr_valid = valid_s4;
	assign write_enable = we_s4;
	assign new_pixel = pix_s4;

	a_accept_lands_s1: assert property (@(posedge clk) disable iff (!arst_n)
		(pix_valid && !pix_stall) |=> (valid_s1 && old_s1 == $past(old_pixel)))
		else $error("accepted beat did not reach stage one");

	a_nowrite_keeps_old: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && !we_s2) |-> (sel_s2 == SEL_OLD))
		else $error("non-written pixel does not select the old value");

	a_blend_opaque: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && valid_s3 && sel_s3 == SEL_BLEND) |=>
		(wr_valid && write_enable && new_pixel[31:24] == 8'hFF))
		else $error("blended pixel lost its write or opaque top byte");

	a_hold_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> ($stable(valid_s2) && $stable(prod_s2) && $stable(quot_s3)))
		else $error("pipeline moved while the result beat was stalled");

endmodule

`default_nettype wire
